FILE: src/conv3x3_zero_pad_stream_unit_macros.svh
// Assertion helpers included by the stream unit RTL.
`ifndef CONV3X3_ZERO_PAD_STREAM_UNIT_MACROS_SVH
`define CONV3X3_ZERO_PAD_STREAM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define C3ZP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define C3ZP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/c3zp_pkg.sv
package c3zp_pkg;

  localparam int IMAGE_SIZE_DEF     = 8;
  localparam int PIXEL_BITS_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam int COEF_W     = 16;
  localparam int TAPS       = 3;
  localparam int KERNEL_W   = TAPS * COEF_W;
  localparam int FILT_W     = 36;
  localparam int POS_OUT_W  = 3;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_TOP = 2'd0,
    CFG_KERNEL_MID = 2'd1,
    CFG_KERNEL_BOT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 last;
    logic                 done;
  } tag_t;

  // Box filter: round(2^frac / 9) in all three taps of a row.
  function automatic logic [KERNEL_W-1:0] kernel_reset(input int frac);
    logic [COEF_W-1:0] c;
    c = COEF_W'((2 * (1 << frac) + 9) / 18);
    return {c, c, c};
  endfunction

endpackage

FILE: src/c3zp_in_if.sv
interface c3zp_in_if
  import c3zp_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output func, output pixel, input ready);
  modport sink   (input valid, input func, input pixel, output ready);
endinterface

FILE: src/c3zp_out_if.sv
interface c3zp_out_if
  import c3zp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [FILT_W-1:0] filtered;
  logic [POS_OUT_W-1:0]     out_row;
  logic [POS_OUT_W-1:0]     out_col;
  logic                     last_of_run;
  logic                     frame_done;

  modport source (output valid, output filtered, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input filtered, input out_row, input out_col,
                  input last_of_run, input frame_done, output ready);
endinterface

FILE: src/c3zp_ram.sv
module c3zp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr0,
  input  logic [AddrW-1:0] raddr1,
  output logic [WIDTH-1:0] rdata0_r,
  output logic [WIDTH-1:0] rdata1_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

endmodule

FILE: src/conv3x3_zero_pad_stream_unit.sv
// Streaming 3x3 correlation over an IMAGE_SIZE x IMAGE_SIZE image with zero
// padding. Pixels enter in raster order; each result is the exact sum of nine
// coefficient x pixel products (14 fractional bits for the default kernel
// format), tagged with its row and column. A new item is taken every cycle
// while the output is not stalled, except that the pixel closing any row
// below the first holds the input until its second result has issued, since
// its two results share the single nine-multiplier stage and leave one after
// the other. The line store is read as the item is registered, then the
// products and the sum are registered in turn, and the second result of a row
// end follows the first. After the last pixel of a frame,
// IMAGE_SIZE drain ticks deliver the final row, one result per tick; drain
// ticks at other times are consumed silently. The two line stores live in one
// IMAGE_SIZE-word RAM with two read ports and are not cleared after reset:
// rows above the image are zeroed by position, so no clearing pass is needed.
`include "conv3x3_zero_pad_stream_unit_macros.svh"

module conv3x3_zero_pad_stream_unit
  import c3zp_pkg::*;
#(
  parameter int IMAGE_SIZE     = IMAGE_SIZE_DEF,
  parameter int PIXEL_BITS     = PIXEL_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KERNEL_W-1:0]  cfg_wdata,
  c3zp_in_if.sink              in_stream,
  c3zp_out_if.source           out_stream
);

  localparam int PosW  = $clog2(IMAGE_SIZE);
  localparam int RamW  = 2 * PIXEL_BITS;
  localparam int ProdW = PIXEL_BITS + COEF_W;
  localparam int SumW  = ProdW + 4;
  localparam int ExtW  = SumW + FILT_W;
  localparam logic [PosW-1:0]     LastPos     = PosW'(IMAGE_SIZE - 1);
  localparam logic [KERNEL_W-1:0] KernelReset = kernel_reset(COEF_FRAC_BITS);

  typedef logic signed [PIXEL_BITS-1:0] pix_t;
  typedef logic signed [ProdW-1:0]      prod_t;

  function automatic logic [POS_OUT_W-1:0] pos_out(input logic [PosW-1:0] p);
    logic [PosW+POS_OUT_W-1:0] w;
    w = {{POS_OUT_W{1'b0}}, p};
    return w[POS_OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- kernel
  logic [KERNEL_W-1:0] kern_r [TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        kern_r[k] <= KernelReset;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KERNEL_TOP: kern_r[0] <= cfg_wdata;
        CFG_KERNEL_MID: kern_r[1] <= cfg_wdata;
        CFG_KERNEL_BOT: kern_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------- frame position
  logic            in_accept;
  logic            in_drain;
  logic            a_load;
  logic [PosW-1:0] row_r, row_nxt;
  logic [PosW-1:0] col_r, col_nxt;
  logic            drn_act_r, drn_act_nxt;
  logic [PosW-1:0] drn_col_r, drn_col_nxt;

  assign in_accept = in_stream.valid && in_stream.ready;
  assign in_drain  = in_stream.func == FUNC_DRAIN;
  // Drain ticks with nothing pending are consumed and dropped here.
  assign a_load    = in_accept && (!in_drain || drn_act_r);

  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    drn_act_nxt = drn_act_r;
    drn_col_nxt = drn_col_r;
    if (in_accept) begin
      if (!in_drain) begin
        drn_act_nxt = 1'b0;
        col_nxt     = PosW'(col_r + 1'b1);
        if (col_r == LastPos) begin
          col_nxt = '0;
          if (row_r == LastPos) begin
            row_nxt     = '0;
            drn_act_nxt = 1'b1;
            drn_col_nxt = '0;
          end else begin
            row_nxt = PosW'(row_r + 1'b1);
          end
        end
      end else if (drn_act_r) begin
        drn_col_nxt = PosW'(drn_col_r + 1'b1);
        if (drn_col_r == LastPos) begin
          drn_act_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      drn_act_r <= 1'b0;
      drn_col_r <= '0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      drn_act_r <= drn_act_nxt;
      drn_col_r <= drn_col_nxt;
    end
  end

  // ------------------------------------------------------------ line store
  // Word layout: newer row in the upper half, older row in the lower half.
  logic            ram_we;
  logic [PosW-1:0] ram_waddr;
  logic [RamW-1:0] ram_wdata;
  logic [PosW-1:0] ram_raddr0;
  logic [PosW-1:0] ram_raddr1;
  logic [RamW-1:0] ram_rdata0;
  logic [RamW-1:0] ram_rdata1;

  // A drain tick fetches the column right of its own; column 0 comes on port 1.
  assign ram_raddr0 = in_drain ? PosW'(drn_col_r + 1'b1) : col_r;
  assign ram_raddr1 = '0;

  c3zp_ram #(
    .WIDTH (RamW),
    .DEPTH (IMAGE_SIZE)
  ) u_line_ram (
    .clk      (clk),
    .we       (ram_we),
    .waddr    (ram_waddr),
    .wdata    (ram_wdata),
    .re       (a_load),
    .raddr0   (ram_raddr0),
    .raddr1   (ram_raddr1),
    .rdata0_r (ram_rdata0),
    .rdata1_r (ram_rdata1)
  );

  // ----------------------------------------------------- window / issue stage
  logic            a_valid_r;
  logic            a_ph_r;
  logic            a_drain_r;
  pix_t            a_pixel_r;
  logic [PosW-1:0] a_row_r;
  logic [PosW-1:0] a_col_r;
  logic            a_done_r;

  logic            m_free;
  logic            a_fire;
  logic            a_retire;
  logic            has1;
  logic            has2;
  pix_t            win_r   [TAPS][TAPS];
  pix_t            win_nxt [TAPS][TAPS];
  pix_t            jwin    [TAPS][TAPS];
  tag_t            jtag;
  pix_t            rd0_old, rd0_new, rd1_old, rd1_new;

  assign rd0_old = pix_t'(ram_rdata0[PIXEL_BITS-1:0]);
  assign rd0_new = pix_t'(ram_rdata0[RamW-1:PIXEL_BITS]);
  assign rd1_old = pix_t'(ram_rdata1[PIXEL_BITS-1:0]);
  assign rd1_new = pix_t'(ram_rdata1[RamW-1:PIXEL_BITS]);

  assign has1     = a_drain_r || ((a_row_r != '0) && (a_col_r != '0));
  assign has2     = !a_drain_r && has1 && (a_col_r == LastPos);
  assign a_fire   = a_valid_r && m_free;
  assign a_retire = a_fire && (!has2 || a_ph_r);

  assign in_stream.ready = !a_valid_r || a_retire;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      for (int l = 0; l < TAPS; l++) begin
        win_nxt[k][l] = '0;
      end
    end
    if (!a_drain_r) begin
      // Row start: clear the history, the left neighbour is padding.
      if (a_col_r != '0) begin
        for (int k = 0; k < TAPS; k++) begin
          win_nxt[k][0] = win_r[k][1];
          win_nxt[k][1] = win_r[k][2];
        end
      end
      win_nxt[0][2] = (a_row_r >= PosW'(2)) ? rd0_old : '0;
      win_nxt[1][2] = (a_row_r >= PosW'(1)) ? rd0_new : '0;
      win_nxt[2][2] = a_pixel_r;
    end else if (a_col_r == '0) begin
      win_nxt[0][1] = rd1_old;
      win_nxt[1][1] = rd1_new;
      win_nxt[0][2] = rd0_old;
      win_nxt[1][2] = rd0_new;
    end else begin
      for (int k = 0; k < 2; k++) begin
        win_nxt[k][0] = win_r[k][1];
        win_nxt[k][1] = win_r[k][2];
      end
      if (a_col_r != LastPos) begin
        win_nxt[0][2] = rd0_old;
        win_nxt[1][2] = rd0_new;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      if (a_ph_r) begin
        // Right edge: window shifted once more, padding on the right.
        jwin[k][0] = win_r[k][1];
        jwin[k][1] = win_r[k][2];
        jwin[k][2] = '0;
      end else begin
        for (int l = 0; l < TAPS; l++) begin
          jwin[k][l] = win_nxt[k][l];
        end
      end
    end
    if (a_drain_r) begin
      jtag.row  = pos_out(a_row_r);
      jtag.col  = pos_out(a_col_r);
      jtag.last = 1'b1;
      jtag.done = a_done_r;
    end else begin
      jtag.row  = pos_out(PosW'(a_row_r - 1'b1));
      jtag.col  = a_ph_r ? pos_out(a_col_r) : pos_out(PosW'(a_col_r - 1'b1));
      jtag.last = a_ph_r || !has2;
      jtag.done = 1'b0;
    end
  end

  assign ram_we    = a_fire && !a_ph_r && !a_drain_r;
  assign ram_waddr = a_col_r;
  assign ram_wdata = {a_pixel_r, rd0_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_ph_r    <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= 1'b1;
      end else if (a_retire) begin
        a_valid_r <= 1'b0;
      end
      if (a_retire) begin
        a_ph_r <= 1'b0;
      end else if (a_fire && has2) begin
        a_ph_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_drain_r <= in_drain;
      a_pixel_r <= in_stream.pixel;
      a_row_r   <= in_drain ? LastPos : row_r;
      a_col_r   <= in_drain ? drn_col_r : col_r;
      a_done_r  <= drn_col_r == LastPos;
    end
    if (a_fire && !a_ph_r) begin
      win_r <= win_nxt;
    end
  end

  // --------------------------------------------------------- multiply stage
  logic  m_valid_r;
  prod_t m_prod_r [TAPS][TAPS];
  tag_t  m_tag_r;
  logic  out_free;
  logic  out_valid_r;

  assign out_free = !out_valid_r || out_stream.ready;
  assign m_free   = !m_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_free) begin
      m_valid_r <= a_fire && has1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_free && a_fire && has1) begin
      for (int k = 0; k < TAPS; k++) begin
        for (int l = 0; l < TAPS; l++) begin
          m_prod_r[k][l] <= prod_t'($signed(kern_r[k][l*COEF_W +: COEF_W]))
                          * prod_t'(jwin[k][l]);
        end
      end
      m_tag_r <= jtag;
    end
  end

  // -------------------------------------------------------------- sum stage
  logic signed [SumW-1:0]   row_sum [TAPS];
  logic signed [SumW-1:0]   m_sum;
  logic signed [ExtW-1:0]   m_ext;
  logic signed [FILT_W-1:0] out_filt_r;
  tag_t                     out_tag_r;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      row_sum[k] = SumW'(m_prod_r[k][0]) + SumW'(m_prod_r[k][1]) + SumW'(m_prod_r[k][2]);
    end
    m_sum = row_sum[0] + row_sum[1] + row_sum[2];
    m_ext = ExtW'(m_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && m_valid_r) begin
      out_filt_r <= m_ext[FILT_W-1:0];
      out_tag_r  <= m_tag_r;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.filtered    = out_filt_r;
  assign out_stream.out_row     = out_tag_r.row;
  assign out_stream.out_col     = out_tag_r.col;
  assign out_stream.last_of_run = out_tag_r.last;
  assign out_stream.frame_done  = out_tag_r.done;

  // ------------------------------------------------------------- assertions
  `C3ZP_ASSERT_NOW(a_ram_no_collide, clk, rst_n, ram_we && a_load,
                   ram_waddr != ram_raddr0, "line store written and read at one address")
  `C3ZP_ASSERT_NOW(a_second_at_row_end, clk, rst_n, a_ph_r,
                   a_valid_r && !a_drain_r && (a_col_r == LastPos),
                   "second result outside a row end")
  `C3ZP_ASSERT_NOW(a_drain_at_origin, clk, rst_n, drn_act_r,
                   (row_r == '0) && (col_r == '0), "drain pending while frame position moved")
  `C3ZP_ASSERT_NOW(a_done_is_last, clk, rst_n, out_valid_r && out_tag_r.done,
                   out_tag_r.last && (out_tag_r.col == pos_out(LastPos)),
                   "frame end flag on a non-final result")

endmodule
